@@ sv/mrcs_pkg.sv @@
package mrcs_pkg;

  localparam int NUM_COILS_DEF   = 2;
  localparam int FRAME_BYTES_DEF = 64;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_CHAR_GAP   = 2'd1;
  localparam logic [1:0] CFG_FRAME_GAP  = 2'd2;

  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_INPUTS = 8'h02;
  localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FN_WRITE_MULTI = 8'h0F;
  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [7:0] EXC_FUNC       = 8'h01;
  localparam logic [7:0] EXC_ADDR       = 8'h02;
  localparam logic [7:0] EXC_VALUE      = 8'h03;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [1:0] {PH_IDLE, PH_RECV, PH_WAIT} phase_t;

  // controller sequence
  typedef enum logic [3:0] {
    ST_IDLE, ST_STORE, ST_LOAD, ST_FETCH, ST_EXEC, ST_BUILD, ST_CRC, ST_SEND, ST_HOLD
  } state_t;

  typedef struct packed {
    logic store;     // write rx byte into frame store
    logic tick;      // silent tick bookkeeping
    logic load;      // issue read of header byte
    logic fetch;     // capture read data
    logic exec;      // decode and apply request
    logic build;     // latch next response byte, start crc
    logic crc_step;  // one crc bit step
    logic send;      // present byte
    logic finish;    // end of exchange
  } cmd_t;

  typedef struct packed {
    logic respond;   // frame gap reached with a non-empty frame
    logic drop;      // address byte does not match, nothing to send
    logic fetch_done;
    logic crc_done;
    logic last;      // byte just built is final
  } sts_t;

  // one bit step of CRC-16/Modbus
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

@@ sv/mrcs_ctrl.sv @@
module mrcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_mode,
  output logic          out_valid,
  input  logic          out_stall,
  input  mrcs_pkg::sts_t sts,
  output mrcs_pkg::cmd_t cmd
);
  import mrcs_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = in_mode ? ST_LOAD : ST_STORE;
      ST_STORE: state_nxt = ST_IDLE;
      ST_LOAD:  begin
        if (sts.respond) state_nxt = ST_FETCH;
        else state_nxt = ST_IDLE;
      end
      ST_FETCH: begin
        if (sts.fetch_done) state_nxt = sts.drop ? ST_IDLE : ST_EXEC;
      end
      ST_EXEC:  state_nxt = ST_BUILD;
      ST_BUILD: state_nxt = ST_CRC;
      ST_CRC:   if (sts.crc_done) state_nxt = ST_SEND;
      ST_SEND:  state_nxt = ST_HOLD;
      ST_HOLD:  begin
        if (!out_stall) state_nxt = sts.last ? ST_IDLE : ST_BUILD;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_HOLD);
    case (state_r)
      ST_IDLE:  cmd.tick = in_valid & in_mode;
      ST_STORE: cmd.store = 1'b1;
      ST_LOAD:  cmd.load = sts.respond;
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        // address mismatch: discard the frame without a response
        cmd.finish = sts.fetch_done & sts.drop;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_BUILD: cmd.build = 1'b1;
      ST_CRC:   cmd.crc_step = 1'b1;
      ST_SEND:  cmd.send = 1'b1;
      ST_HOLD:  cmd.finish = !out_stall & sts.last;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

@@ sv/mrcs_dp.sv @@
module mrcs_dp #(
  parameter int NUM_COILS   = mrcs_pkg::NUM_COILS_DEF,
  parameter int FRAME_BYTES = mrcs_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_rx_byte,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  mrcs_pkg::cmd_t cmd,
  output mrcs_pkg::sts_t sts,
  output logic [7:0]     out_tx_byte,
  output logic           out_last_byte,
  output logic [1:0]     out_coil_levels
);
  import mrcs_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int CW = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [7:0]  rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [7:0]  addr_r;
  logic [15:0] cgap_r, fgap_r, sil_r;
  logic [LW-1:0] len_r;
  phase_t      ph_r;
  logic [NUM_COILS-1:0] coil_r;
  logic        resp_r;
  logic [7:0]  hdr_r [8];       // bytes 0..7 of the frame
  logic [3:0]  fi_r;            // fetch index
  logic        fv_r;            // read in flight
  logic [7:0]  rsp_r [6];
  logic [2:0]  rlen_r;          // response length without crc
  logic [3:0]  bi_r;            // next byte to build
  logic [15:0] crc_r;
  logic [2:0]  ci_r;
  logic [7:0]  tx_r;
  logic        last_r;

  // header byte with short-frame zero fill
  function automatic logic [7:0] hb(input int i);
    hb = hdr_r[i];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 8'd1; cgap_r <= 16'd15; fgap_r <= 16'd35;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: addr_r <= cfg_data[7:0];
        CFG_CHAR_GAP:   cgap_r <= cfg_data;
        CFG_FRAME_GAP:  fgap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame memory, registered read
  assign rd_addr = AW'(fi_r);
  always_ff @(posedge clk) begin
    if (cmd.store && (len_r < LW'(FRAME_BYTES)) && (ph_r != PH_WAIT))
      frame_mem[len_r[AW-1:0]] <= in_rx_byte;
    rd_data_r <= frame_mem[rd_addr];
  end

  // link timing: each tick decides whether to respond
  logic [15:0] sil_inc;
  logic        wait_now, gap_hit;
  assign sil_inc  = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
  assign wait_now = (ph_r == PH_WAIT) || ((ph_r == PH_RECV) && (sil_inc >= cgap_r));
  assign gap_hit  = wait_now && (sil_inc >= fgap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sil_r <= '0; len_r <= '0; ph_r <= PH_IDLE; resp_r <= 1'b0;
    end else begin
      if (cmd.store && ph_r != PH_WAIT) begin
        if (len_r < LW'(FRAME_BYTES)) len_r <= len_r + LW'(1);
        sil_r <= '0;
        ph_r  <= PH_RECV;
      end
      if (cmd.tick) begin
        sil_r  <= sil_inc;
        resp_r <= gap_hit && (len_r != '0);
        if (gap_hit && (len_r == '0)) ph_r <= PH_IDLE;
        else if (wait_now) ph_r <= PH_WAIT;
      end
      if (cmd.finish) begin
        len_r <= '0; ph_r <= PH_IDLE;
      end
    end
  end

  // address match is known once the header is fetched
  assign sts.respond    = resp_r;
  assign sts.drop       = (hdr_r[0] != addr_r);
  assign sts.fetch_done = fv_r && (fi_r == 4'd9);
  assign sts.crc_done   = (ci_r == 3'd7);
  assign sts.last       = last_r;

  // fetch header bytes 0..7
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r <= '0; fv_r <= 1'b0;
    end else if (cmd.load) begin
      fi_r <= '0; fv_r <= 1'b0;
    end else if (cmd.fetch && !sts.fetch_done) begin
      fv_r <= 1'b1;
      fi_r <= fi_r + 4'd1;
      if (fv_r) hdr_r[fi_r[2:0] - 3'd1] <=
        (LW'(fi_r - 4'd1) < len_r) ? rd_data_r : 8'h00;
    end
  end

  // decode and execute
  logic [7:0]  fn, bc;
  logic [15:0] start, qty;
  logic [16:0] endc;
  logic [13:0] nby;
  logic        match;
  logic [7:0]  code;
  logic [NUM_COILS-1:0] coil_new;
  logic [7:0]  rdata;
  logic [2:0]  ok_len;
  always_comb begin
    fn = hb(1); start = {hb(2), hb(3)}; qty = {hb(4), hb(5)}; bc = hb(6);
    endc = {1'b0, start} + {1'b0, qty};
    nby = {1'b0, qty[15:3]} + {13'd0, (qty[2:0] != 3'd0)};
    match = (hb(0) == addr_r);
    code = 8'h00; coil_new = coil_r; rdata = 8'h00; ok_len = 3'd3;
    if (fn == FN_READ_COILS || fn == FN_READ_INPUTS) begin
      if (qty == 16'd0) code = EXC_VALUE;
      else if (endc > 17'(NUM_COILS)) code = EXC_ADDR;
      else begin
        for (int i = 0; i < NUM_COILS; i++)
          if (17'(i) < {1'b0, qty}) rdata[i] = coil_r[CW'(start) + CW'(i)];
        ok_len = 3'd4;
      end
    end else if (fn == FN_WRITE_COIL) begin
      if (qty != COIL_ON && qty != 16'd0) code = EXC_VALUE;
      else if (start >= 16'(NUM_COILS)) code = EXC_ADDR;
      else begin
        coil_new[CW'(start)] = (qty == COIL_ON);
        ok_len = 3'd6;
      end
    end else if (fn == FN_WRITE_MULTI) begin
      if (qty == 16'd0 || {6'd0, bc} != nby) code = EXC_VALUE;
      else if (endc > 17'(NUM_COILS)) code = EXC_ADDR;
      else begin
        for (int i = 0; i < NUM_COILS; i++)
          if (17'(i) < {1'b0, qty}) coil_new[CW'(start) + CW'(i)] = hdr_r[7][i];
        ok_len = 3'd6;
      end
    end else code = EXC_FUNC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_r <= '0;
    end else if (cmd.exec && match) begin
      coil_r <= coil_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_r[0] <= hb(0);
      if (code != 8'h00) begin
        rsp_r[1] <= fn | EXC_FLAG; rsp_r[2] <= code; rlen_r <= 3'd3;
      end else begin
        rsp_r[1] <= fn; rlen_r <= ok_len;
        if (ok_len == 3'd4) begin
          rsp_r[2] <= 8'd1; rsp_r[3] <= rdata;
        end else begin
          rsp_r[2] <= hb(2); rsp_r[3] <= hb(3); rsp_r[4] <= hb(4); rsp_r[5] <= hb(5);
        end
      end
    end
  end

  // byte builder with bit-serial crc
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      bi_r <= '0; crc_r <= CRC_INIT;
    end
    if (cmd.build) begin
      ci_r <= '0;
      if (bi_r < {1'b0, rlen_r}) begin
        tx_r <= rsp_r[bi_r[2:0]];
        crc_r <= crc_bit(crc_r ^ {8'h00, rsp_r[bi_r[2:0]]});
        last_r <= 1'b0;
      end else if (bi_r == {1'b0, rlen_r}) begin
        tx_r <= crc_r[7:0]; last_r <= 1'b0;
      end else begin
        tx_r <= crc_r[15:8]; last_r <= 1'b1;
      end
      bi_r <= bi_r + 4'd1;
    end
    if (cmd.crc_step) begin
      ci_r <= ci_r + 3'd1;
      if (bi_r <= {1'b0, rlen_r} && ci_r != 3'd7) crc_r <= crc_bit(crc_r);
    end
  end

  assign out_tx_byte     = tx_r;
  assign out_last_byte   = last_r;
  assign out_coil_levels = 2'(coil_r);
endmodule

@@ sv/modbus_rtu_coil_slave_core.sv @@
// Flow: a byte goes through the store state; a tick through the load state, or
// at the frame gap on to fetch and decode, then build, CRC and send per response
// byte (bit-serial CRC loop over 8 steps) and a hold while the output stalls.
// One item at a time, input stalled until done; a full response is 8 bytes.
// Reset: synchronous active-low rst_n restores registers 1/15/35, clears
// coils, frame length and silence count; frame memory contents are undefined.
module modbus_rtu_coil_slave_core #(
  parameter int NUM_COILS   = mrcs_pkg::NUM_COILS_DEF,
  parameter int FRAME_BYTES = mrcs_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte,
  output logic [1:0]  out_coil_levels,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mrcs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [7:0] rx_r;

  assign cfg_ready = 1'b1;

  // hold the received byte for the store cycle
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) rx_r <= in_rx_byte;
  end

  mrcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode,
    .out_valid, .out_stall, .sts, .cmd
  );

  mrcs_dp #(.NUM_COILS(NUM_COILS), .FRAME_BYTES(FRAME_BYTES)) u_dp (
    .clk, .rst_n, .in_rx_byte(rx_r), .cfg_we(cfg_valid),
    .cfg_index, .cfg_data, .cmd, .sts,
    .out_tx_byte, .out_last_byte, .out_coil_levels
  );
endmodule

@@ sv/mrcs_checker.sv @@
module mrcs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_last_byte,
  input logic [7:0] out_tx_byte
);
  // no new input while a response byte waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during response");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte))
    else $error("result changed under stall");
  // after the final beat no output follows in the next cycle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_byte |=> !out_valid)
    else $error("output after last byte");
endmodule

bind modbus_rtu_coil_slave_core mrcs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_last_byte, .out_tx_byte
);
